// ===== rtl/dqd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the debounced quadrature decoder: widths, reset values,
// register indexes, quadrature state and edge event types, transition table.
// No dependencies.
package dqd_pkg;

	// Default widths for the step accumulator and the per-line sample timers
	localparam int DELTA_WIDTH_DEF = 16;
	localparam int TIMER_WIDTH_DEF = 16;

	// Configuration port
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEBOUNCE_TICKS    = 1'b0,
		REG_BUTTON_ACTIVE_LOW = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST    = 16'd5000;
	localparam logic                  BUTTON_ACTIVE_LOW_RST = 1'b1;

	// Result field width
	localparam int ROT_W = 16;

	// Quadrature phase: which lines are low (both idle high at rest)
	typedef enum logic [1:0] {
		QS_REST     = 2'd0,
		QS_A_LOW    = 2'd1,
		QS_BOTH_LOW = 2'd2,
		QS_B_LOW    = 2'd3
	} quad_state_t;

	// Accepted edge on one encoder line
	typedef enum logic [1:0] {
		EV_A_RISE = 2'd0,
		EV_A_FALL = 2'd1,
		EV_B_RISE = 2'd2,
		EV_B_FALL = 2'd3
	} quad_ev_t;

	// Quadrature transition table
	function automatic quad_state_t quad_next(quad_state_t qs, quad_ev_t ev);
		quad_state_t nxt;
		nxt = qs;
		unique case (qs)
			QS_REST: begin
				unique case (ev)
					EV_A_FALL: nxt = QS_A_LOW;
					EV_B_FALL: nxt = QS_B_LOW;
					default:   nxt = QS_REST;
				endcase
			end
			QS_A_LOW: begin
				unique case (ev)
					EV_A_RISE: nxt = QS_REST;
					EV_B_FALL: nxt = QS_BOTH_LOW;
					default:   nxt = QS_A_LOW;
				endcase
			end
			QS_BOTH_LOW: begin
				unique case (ev)
					EV_A_RISE: nxt = QS_B_LOW;
					EV_B_RISE: nxt = QS_A_LOW;
					default:   nxt = QS_BOTH_LOW;
				endcase
			end
			QS_B_LOW: begin
				unique case (ev)
					EV_A_FALL: nxt = QS_BOTH_LOW;
					EV_B_RISE: nxt = QS_REST;
					default:   nxt = QS_B_LOW;
				endcase
			end
			default: nxt = QS_REST;
		endcase
		return nxt;
	endfunction

endpackage

// ===== rtl/debounced_quadrature_decoder.sv =====
`timescale 1ns / 1ps
// Debounced quadrature decoder top level: input register, edge debounce,
// quadrature machine, step accumulator, button latch and result register.
// Depends on dqd_pkg.
//
// Usage
//   Input channel (in_valid/in_ready) carries one sample per tick: encoder
//   lines pin_a/pin_b, pin_button, and the read strobes read_rotation and
//   read_button. Output channel (out_valid/out_ready) returns exactly one
//   result per sample: rotation_delta (steps since the last read, when
//   read_rotation is set, else 0) and button_event.
//   A sample accepted into the input register is processed and lands in the
//   result register, visible on the output ports from then on. Throughput
//   is one sample per cycle while the receiver takes results; the
//   per-sample work is one pass through the debounce compare, two table
//   lookups, a saturating step decrement and a saturating step increment
//   between the input and result registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more sample; in_ready drops only when both
//   are full.
//   Reset (arst_n low) empties both registers, puts the quadrature machine
//   at rest, clears the step count and button flags, sets all previous line
//   levels high, saturates the debounce timers and loads the configuration
//   defaults (debounce_ticks 5000, button_active_low 1). Configuration is
//   written through cfg_we/cfg_index/cfg_data with the block idle.
module debounced_quadrature_decoder #(
	parameter int DELTA_WIDTH = dqd_pkg::DELTA_WIDTH_DEF,
	parameter int TIMER_WIDTH = dqd_pkg::TIMER_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                pin_a,
	input  logic                                pin_b,
	input  logic                                pin_button,
	input  logic                                read_rotation,
	input  logic                                read_button,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dqd_pkg::ROT_W-1:0]    rotation_delta,
	output logic                                button_event,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [dqd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dqd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int NLINES = 3;
	localparam int LINE_A = 0;
	localparam int LINE_B = 1;
	localparam int LINE_BTN = 2;
	localparam int CMP_W = (TIMER_WIDTH > dqd_pkg::CFG_DATA_W) ? TIMER_WIDTH
		: dqd_pkg::CFG_DATA_W;
	localparam int EXT_W = (DELTA_WIDTH > dqd_pkg::ROT_W) ? DELTA_WIDTH : dqd_pkg::ROT_W;

	localparam logic signed [DELTA_WIDTH-1:0] STEP_MAX = {1'b0, {(DELTA_WIDTH-1){1'b1}}};
	localparam logic signed [DELTA_WIDTH-1:0] STEP_MIN = {1'b1, {(DELTA_WIDTH-1){1'b0}}};
	localparam logic [TIMER_WIDTH-1:0]        TIMER_MAX = {TIMER_WIDTH{1'b1}};

	// Configuration registers
	logic [dqd_pkg::CFG_DATA_W-1:0] debounce_ticks_q;
	logic                           button_active_low_q;

	// Input register
	logic valid_s1;
	logic pin_a_s1, pin_b_s1, pin_button_s1, read_rotation_s1, read_button_s1;

	// Decoder state
	dqd_pkg::quad_state_t          quad_state_q;
	logic signed [DELTA_WIDTH-1:0] step_q;
	logic [NLINES-1:0]             prev_q;
	logic [TIMER_WIDTH-1:0]        since_q [NLINES];
	logic                          button_down_q;
	logic                          press_pending_q;

	// Result register
	logic                              out_valid_q;
	logic signed [dqd_pkg::ROT_W-1:0]  rotation_delta_q;
	logic                              button_event_q;

	logic advance;
	logic [NLINES-1:0]      level;
	logic [NLINES-1:0]      accept;
	logic [TIMER_WIDTH-1:0] since_d [NLINES];

	dqd_pkg::quad_ev_t    ev_a, ev_b;
	dqd_pkg::quad_state_t qs_mid, qs_next;
	logic                 step_dec, step_inc;

	logic signed [DELTA_WIDTH-1:0] step_mid, step_sum, step_d;
	logic signed [EXT_W-1:0]       step_ext;
	logic                          pressed, button_down_d, press_pending_d;
	logic                          evt_d;

	// Handshake: a transaction moves from the input register to the result
	// register whenever the result slot is free or being drained
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign rotation_delta = rotation_delta_q;
	assign button_event   = button_event_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q    <= dqd_pkg::DEBOUNCE_TICKS_RST;
			button_active_low_q <= dqd_pkg::BUTTON_ACTIVE_LOW_RST;
		end else if (cfg_we) begin
			unique case (dqd_pkg::cfg_reg_t'(cfg_index))
				dqd_pkg::REG_DEBOUNCE_TICKS:    debounce_ticks_q <= cfg_data;
				dqd_pkg::REG_BUTTON_ACTIVE_LOW: button_active_low_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pin_a_s1         <= pin_a;
			pin_b_s1         <= pin_b;
			pin_button_s1    <= pin_button;
			read_rotation_s1 <= read_rotation;
			read_button_s1   <= read_button;
		end
	end

	// Per-line debounce: saturating tick count, edge accepted past the limit
	assign level = {pin_button_s1, pin_b_s1, pin_a_s1};

	always_comb begin
		logic [TIMER_WIDTH-1:0] inc;
		for (int i = 0; i < NLINES; i++) begin
			inc = (since_q[i] != TIMER_MAX) ? since_q[i] + 1'b1 : since_q[i];
			accept[i] = (level[i] != prev_q[i]) &&
				(CMP_W'(inc) > CMP_W'(debounce_ticks_q));
			since_d[i] = accept[i] ? '0 : inc;
		end
	end

	// Quadrature next state: A edge first, then B edge
	assign ev_a = pin_a_s1 ? dqd_pkg::EV_A_RISE : dqd_pkg::EV_A_FALL;
	assign ev_b = pin_b_s1 ? dqd_pkg::EV_B_RISE : dqd_pkg::EV_B_FALL;

	always_comb begin
		qs_mid  = accept[LINE_A] ? dqd_pkg::quad_next(quad_state_q, ev_a) : quad_state_q;
		qs_next = accept[LINE_B] ? dqd_pkg::quad_next(qs_mid, ev_b) : qs_mid;
	end

	// Quadrature outputs: count down on closing a counter-clockwise cycle,
	// up on closing a clockwise one
	always_comb begin
		step_dec = accept[LINE_A] && (quad_state_q == dqd_pkg::QS_A_LOW) &&
			(ev_a == dqd_pkg::EV_A_RISE);
		step_inc = accept[LINE_B] && (qs_mid == dqd_pkg::QS_B_LOW) &&
			(ev_b == dqd_pkg::EV_B_RISE);
	end

	// Saturating step accumulator, cleared on read
	always_comb begin
		step_mid = (step_dec && step_q != STEP_MIN) ? step_q - 1'b1 : step_q;
		step_sum = (step_inc && step_mid != STEP_MAX) ? step_mid + 1'b1 : step_mid;
		step_ext = EXT_W'(step_sum);
		step_d   = read_rotation_s1 ? '0 : step_sum;
	end

	// Button press latch
	always_comb begin
		pressed         = button_active_low_q ? !pin_button_s1 : pin_button_s1;
		button_down_d   = button_down_q;
		press_pending_d = press_pending_q;
		if (accept[LINE_BTN]) begin
			if (pressed) begin
				if (!button_down_q) begin
					button_down_d   = 1'b1;
					press_pending_d = 1'b1;
				end
			end else begin
				button_down_d   = 1'b0;
				press_pending_d = 1'b0;
			end
		end
		evt_d = read_button_s1 && press_pending_d && button_down_d;
		if (evt_d) begin
			press_pending_d = 1'b0;
		end
	end

	// State update per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_state_q    <= dqd_pkg::QS_REST;
			step_q          <= '0;
			prev_q          <= '1;
			for (int i = 0; i < NLINES; i++) begin
				since_q[i] <= TIMER_MAX;
			end
			button_down_q   <= 1'b0;
			press_pending_q <= 1'b0;
		end else if (advance) begin
			quad_state_q    <= qs_next;
			step_q          <= step_d;
			prev_q          <= level;
			for (int i = 0; i < NLINES; i++) begin
				since_q[i] <= since_d[i];
			end
			button_down_q   <= button_down_d;
			press_pending_q <= press_pending_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rotation_delta_q <= read_rotation_s1 ? step_ext[dqd_pkg::ROT_W-1:0] : '0;
			button_event_q   <= evt_d;
		end
	end

	// Assertions
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a full pipeline");

	a_read_clears_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && read_rotation_s1) |=> (step_q == '0))
		else $error("step count not cleared after rotation read");

	a_event_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && button_event_q) |-> button_down_q)
		else $error("button event reported with button released");

	a_result_from_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result appeared without a processed transaction");

endmodule
